### rtl/trs_pkg.sv
// Shared types and constants for the traffic rate statistics block.
package trs_pkg;

  localparam int CFG_DATA_W  = 17;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_TICKS_PER_HOUR = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_TICKS_PER_DAY  = 1'b1;

  localparam logic [11:0] HOUR_LEN_RESET = 12'd360;
  localparam logic [16:0] DAY_LEN_RESET  = 17'd8640;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;

  typedef struct packed {
    logic [5:0]  slot_index;
    logic [63:0] cumulative_count;
  } in_t;

  typedef struct packed {
    logic [63:0] last_delta;
    logic [63:0] running_average;
    logic [63:0] hourly_average;
    logic [63:0] daily_average;
    logic        hour_rolled;
    logic        day_rolled;
  } out_t;

  typedef struct packed {
    logic [11:0] ticks_per_hour;
    logic [16:0] ticks_per_day;
  } cfg_t;

  typedef struct packed {
    logic        in_range;
    logic [5:0]  slot;
    logic [63:0] count;
  } job_t;

  typedef struct packed {
    logic [63:0] prev_count;
    logic [63:0] avg;
    logic [63:0] hour_sum;
    logic [63:0] hour_avg;
    logic [63:0] day_sum;
    logic [63:0] day_avg;
    logic [11:0] hour_phase;
    logic [16:0] day_phase;
  } rec_t;

endpackage

### rtl/trs_front.sv
// Front end: accepts ticks, checks the slot range and queues them for the back end.
module trs_front #(
  parameter int SLOTS = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  trs_pkg::in_t  in_data,
  input  logic          hold,
  output logic          q_valid,
  input  logic          q_ready,
  output trs_pkg::job_t q_job
);

  trs_pkg::job_t                   fifo_r [trs_pkg::QDEPTH];
  logic [trs_pkg::QPTR_W-1:0]      wr_ptr_r;
  logic [trs_pkg::QPTR_W-1:0]      rd_ptr_r;
  logic [trs_pkg::QPTR_W:0]        cnt_r;
  logic [trs_pkg::QPTR_W-1:0]      wr_ptr_nxt;
  logic [trs_pkg::QPTR_W-1:0]      rd_ptr_nxt;
  logic [trs_pkg::QPTR_W:0]        cnt_nxt;
  logic                            push;
  logic                            pop;
  trs_pkg::job_t                   job;

  always_comb begin
    job.in_range = (int'(in_data.slot_index) < SLOTS);
    job.slot     = in_data.slot_index;
    job.count    = in_data.cumulative_count;
  end

  assign in_ready = (cnt_r != (trs_pkg::QPTR_W+1)'(trs_pkg::QDEPTH)) && !hold;
  assign q_valid  = (cnt_r != '0);
  assign q_job    = fifo_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= job;
    end
  end

endmodule

### rtl/trs_back.sv
// Back end: per-slot record memory, read-modify-write update and result register.
module trs_back #(
  parameter int SLOTS = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  trs_pkg::cfg_t cfg,
  input  logic          q_valid,
  output logic          q_ready,
  input  trs_pkg::job_t q_job,
  output logic          clearing,
  output logic          out_valid,
  input  logic          out_ready,
  output trs_pkg::out_t out_data
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_CALC  = 2'd2;

  trs_pkg::rec_t mem [SLOTS];

  logic [1:0]     state_r, state_nxt;
  logic [AW-1:0]  clr_addr_r, clr_addr_nxt;
  logic           out_valid_r, out_valid_nxt;
  trs_pkg::out_t  out_data_r;
  trs_pkg::job_t  job_r;
  trs_pkg::rec_t  rd_rec_r;

  logic           take;
  logic           load_out;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  trs_pkg::rec_t  mem_wdata;
  trs_pkg::rec_t  new_rec;
  trs_pkg::out_t  result;

  // update datapath
  logic        gt;
  logic [63:0] diff;
  logic [63:0] delta;
  logic [63:0] avg_sum;
  logic [63:0] hsum_new;
  logic [63:0] dsum_new;
  logic [63:0] hfold_sum;
  logic [63:0] dfold_sum;
  logic [11:0] hnext;
  logic [16:0] dnext;
  logic        hroll;
  logic        droll;

  always_comb begin
    gt   = job_r.count > rd_rec_r.prev_count;
    diff = job_r.count - rd_rec_r.prev_count;
    // both cases computed side by side so the compare only drives the select
    if (gt) begin
      delta     = diff;
      avg_sum   = job_r.count - rd_rec_r.prev_count + rd_rec_r.avg;
      hsum_new  = rd_rec_r.hour_sum + job_r.count - rd_rec_r.prev_count;
      dsum_new  = rd_rec_r.day_sum + job_r.count - rd_rec_r.prev_count;
      hfold_sum = rd_rec_r.hour_sum + job_r.count - rd_rec_r.prev_count + rd_rec_r.hour_avg;
      dfold_sum = rd_rec_r.day_sum + job_r.count - rd_rec_r.prev_count + rd_rec_r.day_avg;
    end else begin
      delta     = '0;
      avg_sum   = rd_rec_r.avg;
      hsum_new  = rd_rec_r.hour_sum;
      dsum_new  = rd_rec_r.day_sum;
      hfold_sum = rd_rec_r.hour_sum + rd_rec_r.hour_avg;
      dfold_sum = rd_rec_r.day_sum + rd_rec_r.day_avg;
    end

    // phase wraps at its width; a zero length closes every window
    hnext = rd_rec_r.hour_phase + 12'd1;
    dnext = rd_rec_r.day_phase + 17'd1;
    hroll = (hnext >= cfg.ticks_per_hour) || (hnext == '0);
    droll = (dnext >= cfg.ticks_per_day) || (dnext == '0);

    new_rec.prev_count = job_r.count;
    new_rec.avg        = avg_sum >> 1;
    new_rec.hour_sum   = hroll ? '0 : hsum_new;
    new_rec.hour_avg   = hroll ? (hfold_sum >> 1) : rd_rec_r.hour_avg;
    new_rec.day_sum    = droll ? '0 : dsum_new;
    new_rec.day_avg    = droll ? (dfold_sum >> 1) : rd_rec_r.day_avg;
    new_rec.hour_phase = hroll ? '0 : hnext;
    new_rec.day_phase  = droll ? '0 : dnext;

    if (job_r.in_range) begin
      result.last_delta      = delta;
      result.running_average = new_rec.avg;
      result.hourly_average  = new_rec.hour_avg;
      result.daily_average   = new_rec.day_avg;
      result.hour_rolled     = hroll;
      result.day_rolled      = droll;
    end else begin
      result = '0;
    end
  end

  assign q_ready   = (state_r == ST_IDLE);
  assign take      = q_valid && q_ready;
  assign clearing  = (state_r == ST_CLEAR);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    load_out      = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = AW'(job_r.slot);
    mem_wdata     = new_rec;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        mem_wdata    = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(SLOTS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (take) begin
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        // commit the result, and the record of an in-range slot, together once the output slot frees
        if (!out_valid_r || out_ready) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          mem_we        = job_r.in_range;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      job_r <= q_job;
    end
    if (load_out) begin
      out_data_r <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (take) begin
      rd_rec_r <= mem[AW'(q_job.slot)];
    end
  end

endmodule

### rtl/traffic_rate_statistics_top.sv
// Top level of the traffic rate statistics block: configuration registers and the two halves.
//
// Each input beat is one statistics tick for one slot: slot_index and that
// slot's cumulative connection count. Each tick gives exactly one result beat
// with the delta since the slot's previous tick, the running average and the
// slot's hourly and daily averages, plus flags for a closed hour or day window.
// A slot index at or past SLOTS changes nothing and gives an all-zero result.
// Both channels are valid/ready. The front end queues up to two ticks, so input
// beats are taken while a result still waits at the output register.
// With no stall, an accepted tick passes the queue, then the job and record registers, then
// the result register. The back end takes a new tick only after the last one's record is
// written: a read-modify-write of one slot record in the single-ported record memory (read,
// then update and write). Reset starts a clearing pass over all SLOTS records; in_ready
// stays low until it ends. Configuration writes on cfg_we land in cfg_r; the user must do
// them only while no tick is in flight, as the block does not enforce it. A stalled receiver
// holds the result register, then the back end, and then the queue fills and in_ready drops.
module traffic_rate_statistics_top #(
  parameter int SLOTS = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  trs_pkg::in_t                        in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output trs_pkg::out_t                       out_data,
  input  logic                                cfg_we,
  input  logic [trs_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [trs_pkg::CFG_DATA_W-1:0]      cfg_data
);

  trs_pkg::cfg_t cfg_r, cfg_nxt;
  logic          q_valid;
  logic          q_ready;
  trs_pkg::job_t q_job;
  logic          back_clearing;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        trs_pkg::REG_TICKS_PER_HOUR: cfg_nxt.ticks_per_hour = cfg_data[11:0];
        trs_pkg::REG_TICKS_PER_DAY:  cfg_nxt.ticks_per_day  = cfg_data[16:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ticks_per_hour <= trs_pkg::HOUR_LEN_RESET;
      cfg_r.ticks_per_day  <= trs_pkg::DAY_LEN_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  trs_front #(
    .SLOTS(SLOTS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .hold     (back_clearing),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_job    (q_job)
  );

  trs_back #(
    .SLOTS(SLOTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_job     (q_job),
    .clearing  (back_clearing),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // no beats move while the record memory is being cleared
  assert property (@(posedge clk) disable iff (!rst_n)
    back_clearing |-> (!in_ready && !out_valid))
    else $error("beat traffic during memory clear");

  // back end takes no new queued tick until the record write of the last one has landed
  assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && q_ready) |=> !q_ready)
    else $error("back end took ticks on consecutive cycles");

  // an accepted input beat is visible in the queue on the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> q_valid)
    else $error("accepted tick missing from queue");

endmodule
